// File: rtl/core/edge_interrupt_line_controller_core_defines.svh
// assertion macros for the edge interrupt line controller core
// needs clk and rst_n in the scope of the module that uses them
`ifndef EDGE_INTERRUPT_LINE_CONTROLLER_CORE_DEFINES_SVH
`define EDGE_INTERRUPT_LINE_CONTROLLER_CORE_DEFINES_SVH

// antecedent holds in a cycle, consequent holds in the same cycle
`define EILC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eilc assertion failed");

// antecedent holds in a cycle, consequent holds in the next cycle
`define EILC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eilc assertion failed");

`endif

// File: rtl/core/eilc_pkg.sv
// shared types, constants and helper functions of the interrupt line controller
// no dependencies
package eilc_pkg;

  // line count and field widths
  localparam int LINE_COUNT = 20;
  localparam int FIELD_W    = 20;
  localparam int IRQ_W      = 11;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;

  // lines at or above LINE_COUNT never take part
  localparam logic [FIELD_W-1:0] LIVE_MASK = (LINE_COUNT >= FIELD_W) ? {FIELD_W{1'b1}} :
    FIELD_W'((64'd1 << LINE_COUNT) - 64'd1);

  // operation codes
  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd1;
  localparam logic [OP_W-1:0] OP_TRIGGER = 2'd2;
  localparam logic [OP_W-1:0] OP_READ    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISING_SELECT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALLING_SELECT = 2'd2;

  // one input beat
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] line_levels;
    logic [FIELD_W-1:0] line_mask;
  } in_beat_t;

  // one result beat
  typedef struct packed {
    logic [FIELD_W-1:0] pending_flags;
    logic [IRQ_W-1:0]   irq_requests;
  } res_beat_t;

  // fold per-line requests into the grouped request vector
  function automatic logic [IRQ_W-1:0] group_requests(input logic [FIELD_W-1:0] req);
    logic [IRQ_W-1:0] g;
    g[4:0]  = req[4:0];
    g[5]    = |req[9:5];
    g[6]    = |req[15:10];
    g[10:7] = req[19:16];
    return g;
  endfunction

endpackage

// File: rtl/core/eilc_line_state.sv
// configuration masks, line level and pending registers, per-beat update
// depends on eilc_pkg
module eilc_line_state (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [eilc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [eilc_pkg::FIELD_W-1:0]         cfg_wdata,
  input  logic                                 beat_accept,
  input  eilc_pkg::in_beat_t                   beat_in,
  output eilc_pkg::res_beat_t                  res_out
);
  import eilc_pkg::*;

  logic [FIELD_W-1:0] line_enable_r;
  logic [FIELD_W-1:0] rising_select_r;
  logic [FIELD_W-1:0] falling_select_r;
  logic [FIELD_W-1:0] previous_levels_r;
  logic [FIELD_W-1:0] previous_levels_nxt;
  logic [FIELD_W-1:0] pending_r;
  logic [FIELD_W-1:0] pending_nxt;
  logic [FIELD_W-1:0] levels;
  logic [FIELD_W-1:0] mask;
  logic [FIELD_W-1:0] en;
  logic [FIELD_W-1:0] hit;
  logic [FIELD_W-1:0] cfg_value;

  // configuration writes, dead lines dropped
  assign cfg_value = cfg_wdata & LIVE_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_enable_r    <= '0;
      rising_select_r  <= '0;
      falling_select_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_ENABLE:    line_enable_r    <= cfg_value;
        REG_RISING_SELECT:  rising_select_r  <= cfg_value;
        REG_FALLING_SELECT: falling_select_r <= cfg_value;
        default: ;
      endcase
    end
  end

  // edge detect against the last sample
  assign levels = beat_in.line_levels & LIVE_MASK;
  assign mask   = beat_in.line_mask & LIVE_MASK;
  assign en     = line_enable_r & LIVE_MASK;
  assign hit    = ((levels & ~previous_levels_r & rising_select_r) |
                   (~levels & previous_levels_r & falling_select_r)) & en;

  // next pending and level state per operation
  always_comb begin
    previous_levels_nxt = previous_levels_r;
    pending_nxt         = pending_r;
    unique case (beat_in.op)
      OP_SAMPLE: begin
        pending_nxt         = pending_r | hit;
        previous_levels_nxt = levels;
      end
      OP_CLEAR:   pending_nxt = pending_r & ~mask;
      OP_TRIGGER: pending_nxt = pending_r | (mask & en);
      OP_READ:    pending_nxt = pending_r;
      default:    pending_nxt = pending_r;
    endcase
    pending_nxt = pending_nxt & LIVE_MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      previous_levels_r <= '0;
      pending_r         <= '0;
    end else if (beat_accept) begin
      previous_levels_r <= previous_levels_nxt;
      pending_r         <= pending_nxt;
    end
  end

  // result of the beat being accepted
  assign res_out.pending_flags = pending_nxt;
  assign res_out.irq_requests  = group_requests(pending_nxt & en);

endmodule

// File: rtl/core/eilc_out_buf.sv
// two-entry result buffer: output register plus skid register
// depends on eilc_pkg
module eilc_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  eilc_pkg::res_beat_t push_data,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output eilc_pkg::res_beat_t out_data
);
  import eilc_pkg::*;

  logic      out_valid_r;
  logic      skid_valid_r;
  res_beat_t out_data_r;
  res_beat_t skid_data_r;
  logic      pop;

  assign pop      = out_valid_r & out_ready;
  assign can_push = ~skid_valid_r;

  // control: occupancy of the two entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_r  <= skid_valid_r | push;
        skid_valid_r <= skid_valid_r & push;
      end else if (push) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= out_valid_r;
      end
    end
  end

  // payload: oldest beat always sits in the output register
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
        if (push) begin
          skid_data_r <= push_data;
        end
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      if (out_valid_r) begin
        skid_data_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/edge_interrupt_line_controller_core.sv
// Edge interrupt line controller, 20 lines. Each input beat is a level sample,
// a write-one-to-clear, a software trigger or a read, and yields exactly one
// result beat with the pending flags and the grouped request vector. The core
// takes one beat per clock: the pending update is a single pass of logic on
// the accepted beat, and the result is registered in the output buffer on
// acceptance. A two-entry output buffer keeps input ready high while one
// result waits; input stalls only when two results are queued.
// Depends on eilc_pkg, eilc_line_state, eilc_out_buf and the assertion header.
`include "edge_interrupt_line_controller_core_defines.svh"

module edge_interrupt_line_controller_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [eilc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [eilc_pkg::FIELD_W-1:0]     cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [eilc_pkg::OP_W-1:0]        in_op,
  input  logic [eilc_pkg::FIELD_W-1:0]     in_line_levels,
  input  logic [eilc_pkg::FIELD_W-1:0]     in_line_mask,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [eilc_pkg::FIELD_W-1:0]     out_pending_flags,
  output logic [eilc_pkg::IRQ_W-1:0]       out_irq_requests
);
  import eilc_pkg::*;

  in_beat_t  beat_in;
  res_beat_t res_beat;
  res_beat_t out_beat;
  logic      accept;

  assign beat_in.op          = in_op;
  assign beat_in.line_levels = in_line_levels;
  assign beat_in.line_mask   = in_line_mask;
  assign accept              = in_valid & in_ready;

  // pending state and per-beat update
  eilc_line_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .beat_accept (accept),
    .beat_in     (beat_in),
    .res_out     (res_beat)
  );

  // result buffering
  eilc_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res_beat),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_beat)
  );

  assign out_pending_flags = out_beat.pending_flags;
  assign out_irq_requests  = out_beat.irq_requests;

  // checks
  `EILC_ASSERT_NEXT(a_accept_gives_result, accept, out_valid)
  `EILC_ASSERT_SAME(a_stall_only_when_full, !in_ready, out_valid)
  `EILC_ASSERT_SAME(a_req_needs_pending, out_valid,
                    (out_irq_requests[4:0] & ~out_pending_flags[4:0]) == 5'd0)
  `EILC_ASSERT_SAME(a_group_req_needs_pending, out_valid && out_irq_requests[5],
                    out_pending_flags[9:5] != 5'd0)

endmodule

// File: verif/edge_interrupt_line_controller_core_test.sv
`timescale 1ns / 100ps
// self-checking bench for edge_interrupt_line_controller_core: directed table, then random phases
// pending flags and grouped requests are predicted in-bench; depends on eilc_pkg and the core
module edge_interrupt_line_controller_core_test;
  import eilc_pkg::*;

  // spare register index, writes to it must have no effect
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [FIELD_W-1:0]   ALL_LINES = {FIELD_W{1'b1}};
  localparam int PHASE_COUNT = 7;
  localparam int PHASE_BEATS = 250;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [1:0]         code;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    bit                 typed;
    res_beat_t          want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0]   cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_op = OP_READ;
  logic [FIELD_W-1:0]   in_line_levels = '0;
  logic [FIELD_W-1:0]   in_line_mask = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [FIELD_W-1:0]   out_pending_flags;
  logic [IRQ_W-1:0]     out_irq_requests;

  // predictor copy of configuration and state
  logic [FIELD_W-1:0] enable_mask, rise_mask, fall_mask;
  logic [FIELD_W-1:0] seen_levels, flag_bits;

  res_beat_t expected_reports[$];
  row_t      directed_rows[$];
  int        mismatch_count = 0;
  bit        tx_calm = 1'b0;
  bit        rx_calm = 1'b0;
  int        rx_stall = 0;

  edge_interrupt_line_controller_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_line_levels   (in_line_levels),
    .in_line_mask     (in_line_mask),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pending_flags(out_pending_flags),
    .out_irq_requests (out_irq_requests)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short idle gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // map each line onto its request group
  function automatic logic [IRQ_W-1:0] fold_requests(input logic [FIELD_W-1:0] req);
    logic [IRQ_W-1:0] g;
    int               slot;
    g = '0;
    for (int n = 0; n < FIELD_W; n++) begin
      if (n < 5) slot = n;
      else if (n < 10) slot = 5;
      else if (n < 16) slot = 6;
      else slot = n - 9;
      g[slot] = g[slot] | req[n];
    end
    return g;
  endfunction

  // advance predicted line state by one operation
  function automatic res_beat_t apply_line_op(input logic [OP_W-1:0] op,
                                              input logic [FIELD_W-1:0] levels,
                                              input logic [FIELD_W-1:0] mask);
    logic [FIELD_W-1:0] lv, mk, en, rise, fall;
    res_beat_t          r;
    lv = levels & LIVE_MASK;
    mk = mask & LIVE_MASK;
    en = enable_mask & LIVE_MASK;
    case (op)
      OP_SAMPLE: begin
        rise = lv & ~seen_levels;
        fall = ~lv & seen_levels;
        flag_bits = flag_bits | (((rise & rise_mask) | (fall & fall_mask)) & en);
        seen_levels = lv;
      end
      OP_CLEAR: flag_bits = flag_bits & ~mk;
      OP_TRIGGER: flag_bits = flag_bits | (mk & en);
      default: ;
    endcase
    flag_bits = flag_bits & LIVE_MASK;
    r.pending_flags = flag_bits;
    r.irq_requests = fold_requests(flag_bits & en);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_row(input row_kind_t kind, input logic [1:0] code,
                         input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b,
                         input bit typed, input logic [FIELD_W-1:0] want_flags,
                         input logic [IRQ_W-1:0] want_irq);
    row_t row;
    row.kind = kind;
    row.code = code;
    row.a = a;
    row.b = b;
    row.typed = typed;
    row.want.pending_flags = want_flags;
    row.want.irq_requests = want_irq;
    directed_rows.push_back(row);
  endtask

  // hold valid until accepted, then record the expected result
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] levels,
                           input logic [FIELD_W-1:0] mask, input bit typed,
                           input res_beat_t want);
    res_beat_t pred;
    int        g;
    in_valid <= 1'b1;
    in_op <= op;
    in_line_levels <= levels;
    in_line_mask <= mask;
    do @(posedge clk); while (!in_ready);
    pred = apply_line_op(op, levels, mask);
    expected_reports.push_back(typed ? want : pred);
    g = tx_calm ? 0 : pick_gap();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write, leaves cfg_we high
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_LINE_ENABLE:    enable_mask = val & LIVE_MASK;
      REG_RISING_SELECT:  rise_mask = val & LIVE_MASK;
      REG_FALLING_SELECT: fall_mask = val & LIVE_MASK;
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random stalls and in-order compare
  always @(posedge clk) begin
    res_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected result beat", 32'(out_pending_flags), '0);
      end else begin
        want = expected_reports.pop_front();
        if (out_pending_flags !== want.pending_flags)
          report_mismatch("pending_flags", 32'(out_pending_flags),
                          32'(want.pending_flags));
        if (out_irq_requests !== want.irq_requests)
          report_mismatch("irq_requests", 32'(out_irq_requests),
                          32'(want.irq_requests));
      end
    end
    if (rx_stall != 0) begin
      rx_stall--;
    end else if (!rx_calm && $urandom_range(0, 99) < 20) begin
      rx_stall = pick_gap();
    end
    out_ready <= (rx_stall == 0);
  end

  // run limit
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  // main sequence
  initial begin
    res_beat_t          none;
    row_t               row;
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] lv, mk, en, rs, fs;
    int                 r;

    none = '0;
    enable_mask = '0;
    rise_mask = '0;
    fall_mask = '0;
    seen_levels = '0;
    flag_bits = '0;

    // directed table: reset state, extremes, every op and the special cases
    add_row(ROW_BEAT, OP_READ,    '0,        '0,        1, '0,        '0);
    add_row(ROW_BEAT, OP_TRIGGER, '0,        ALL_LINES, 1, '0,        '0);
    add_row(ROW_BEAT, OP_SAMPLE,  ALL_LINES, '0,        1, '0,        '0);
    add_row(ROW_REG,  REG_LINE_ENABLE,   ALL_LINES, '0, 0, '0, '0);
    add_row(ROW_REG,  REG_RISING_SELECT, ALL_LINES, '0, 0, '0, '0);
    add_row(ROW_BEAT, OP_SAMPLE,  '0,        '0,        1, '0,        '0);
    add_row(ROW_BEAT, OP_SAMPLE,  ALL_LINES, '0,        1, ALL_LINES, 11'h7ff);
    add_row(ROW_BEAT, OP_CLEAR,   '0,        ALL_LINES, 1, '0,        '0);
    add_row(ROW_BEAT, OP_TRIGGER, ALL_LINES, 20'h00001, 1, 20'h00001, 11'h001);
    add_row(ROW_BEAT, OP_TRIGGER, '0,        20'h80000, 1, 20'h80001, 11'h401);
    add_row(ROW_BEAT, OP_SAMPLE,  ALL_LINES, '0,        1, 20'h80001, 11'h401);
    add_row(ROW_BEAT, OP_CLEAR,   '0,        ALL_LINES, 1, '0,        '0);
    add_row(ROW_REG,  REG_RISING_SELECT,  '0,        '0, 0, '0, '0);
    add_row(ROW_REG,  REG_FALLING_SELECT, ALL_LINES, '0, 0, '0, '0);
    add_row(ROW_BEAT, OP_SAMPLE,  '0,        '0,        1, ALL_LINES, 11'h7ff);
    add_row(ROW_BEAT, OP_READ,    ALL_LINES, ALL_LINES, 1, ALL_LINES, 11'h7ff);
    add_row(ROW_REG,  REG_LINE_ENABLE, '0, '0, 0, '0, '0);
    add_row(ROW_BEAT, OP_READ,    '0,        '0,        1, ALL_LINES, '0);
    add_row(ROW_BEAT, OP_TRIGGER, '0,        ALL_LINES, 1, ALL_LINES, '0);
    add_row(ROW_BEAT, OP_CLEAR,   ALL_LINES, 20'h0000f, 1, 20'hffff0, '0);
    add_row(ROW_REG,  REG_LINE_ENABLE, 20'h003e0, '0, 0, '0, '0);
    add_row(ROW_BEAT, OP_READ,    '0,        '0,        0, '0,        '0);
    add_row(ROW_REG,  REG_SPARE,  ALL_LINES, '0, 0, '0, '0);
    add_row(ROW_BEAT, OP_READ,    '0,        '0,        0, '0,        '0);
    add_row(ROW_REG,  REG_LINE_ENABLE,    20'h0a5c3, '0, 0, '0, '0);
    add_row(ROW_REG,  REG_RISING_SELECT,  20'h5a5a5, '0, 0, '0, '0);
    add_row(ROW_REG,  REG_FALLING_SELECT, 20'h0f0f0, '0, 0, '0, '0);
    add_row(ROW_BEAT, OP_SAMPLE,  20'h12345, '0,        0, '0,        '0);
    add_row(ROW_BEAT, OP_SAMPLE,  20'hedcba, '0,        0, '0,        '0);
    add_row(ROW_BEAT, OP_TRIGGER, '0,        20'h3c00f, 0, '0,        '0);
    add_row(ROW_BEAT, OP_CLEAR,   '0,        20'h0f00f, 0, '0,        '0);

    // synchronous reset
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        drain_results();
        cfg_write(row.code, row.a);
        cfg_done();
      end else begin
        send_beat(row.code, row.a, row.b, row.typed, row.want);
      end
    end

    // random phases, each under its own configuration
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_results();
      case (phase)
        0: begin
          en = ALL_LINES; rs = ALL_LINES; fs = ALL_LINES;
        end
        1: begin
          en = '0; rs = FIELD_W'($urandom); fs = FIELD_W'($urandom);
        end
        2: begin
          en = ALL_LINES; rs = '0; fs = ALL_LINES;
        end
        default: begin
          en = FIELD_W'($urandom); rs = FIELD_W'($urandom); fs = FIELD_W'($urandom);
        end
      endcase
      cfg_write(REG_LINE_ENABLE, en);
      cfg_write(REG_RISING_SELECT, rs);
      cfg_write(REG_FALLING_SELECT, fs);
      if (phase % 2 == 1) cfg_write(REG_SPARE, FIELD_W'($urandom));
      cfg_done();
      // one phase runs with no idling on either side
      tx_calm = (phase == 2);
      rx_calm = (phase == 2);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // hold off the sender until the result side is empty
        if (phase == 3 && n == PHASE_BEATS / 2) drain_results();
        r = $urandom_range(0, 99);
        if (r < 40) op = OP_SAMPLE;
        else if (r < 60) op = OP_CLEAR;
        else if (r < 85) op = OP_TRIGGER;
        else op = OP_READ;
        // levels flip a few lines of the last sample half the time
        r = $urandom_range(0, 9);
        if (r < 5) lv = seen_levels ^ FIELD_W'($urandom & $urandom & $urandom);
        else if (r < 8) lv = FIELD_W'($urandom);
        else lv = (r == 8) ? ALL_LINES : '0;
        mk = ($urandom_range(0, 4) == 0) ? ALL_LINES : FIELD_W'($urandom & $urandom);
        send_beat(op, lv, mk, 0, none);
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // wait out the tail
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
